### hw/rtl/bitmap_first_fit_allocator_assert.svh
// Assertion macros for the bitmap first-fit allocator.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define BFFA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BFFA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFFA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)

`define BFFA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

### hw/rtl/bffa_pkg.sv
// Shared constants, codes and controller/datapath structs for the
// bitmap first-fit allocator. No dependencies.
`timescale 1ns / 1ps

package bffa_pkg;

    // Bitmap sizes and request bound
    localparam int INODE_BITS = 1024;
    localparam int DATA_BITS  = 4096;
    localparam int MAX_BLOCKS = 12;

    // Bitmap word geometry
    localparam int WORD_W        = 32;
    localparam int BITPOS_W      = 5;
    localparam int INODE_WORDS   = (INODE_BITS + WORD_W - 1) / WORD_W;
    localparam int DATA_WORDS    = (DATA_BITS + WORD_W - 1) / WORD_W;
    localparam int INODE_WADDR_W = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
    localparam int DATA_WADDR_W  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int MAP_WADDR_W   = (INODE_WADDR_W > DATA_WADDR_W) ? INODE_WADDR_W
                                                                  : DATA_WADDR_W;
    localparam int MAP_IDX_W     = MAP_WADDR_W + BITPOS_W;
    localparam int SCAN_W        = MAP_WADDR_W + 1;
    localparam int MAP_BITS_MAX  = (INODE_BITS > DATA_BITS) ? INODE_BITS : DATA_BITS;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int COUNT_W     = 4;
    localparam int MARK_W      = 12;
    localparam int NUMBER_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int INODE_LIM_W = 11;
    localparam int DATA_LIM_W  = 13;
    localparam int BASE_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Limit arithmetic width: holds either limit and either bitmap size
    localparam int LIM_BITS_W = $clog2(MAP_BITS_MAX + 1);
    localparam int LIM_CFG_W  = (DATA_LIM_W > INODE_LIM_W) ? DATA_LIM_W : INODE_LIM_W;
    localparam int LIM_W      = (LIM_CFG_W > LIM_BITS_W) ? LIM_CFG_W : LIM_BITS_W;

    // Pick buffer sizing
    localparam int PICK_CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int PICK_IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    // Register reset values
    localparam logic [INODE_LIM_W-1:0] INODE_LIMIT_RESET = 11'd1024;
    localparam logic [DATA_LIM_W-1:0]  DATA_LIMIT_RESET  = 13'd4096;
    localparam logic [BASE_W-1:0]      DATA_BASE_RESET   = 32'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_INODE = 2'd0,
        CMD_ALLOC_DATA  = 2'd1,
        CMD_MARK_INODE  = 2'd2,
        CMD_MARK_DATA   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NONE     = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INODE_LIMIT = 2'd0,
        CFG_DATA_LIMIT  = 2'd1,
        CFG_DATA_BASE   = 2'd2
    } cfg_idx_t;

    // Source of the bitmap word address
    typedef enum logic [1:0] {
        SRC_SCAN = 2'd0,
        SRC_MARK = 2'd1,
        SRC_PICK = 2'd2
    } rd_src_t;

    // Kind of result to load into the output register
    typedef enum logic [1:0] {
        EMIT_IDLE = 2'd0,
        EMIT_PICK = 2'd1,
        EMIT_FAIL = 2'd2,
        EMIT_NONE = 2'd3
    } emit_t;

    // Controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    load_req;
        logic    rd_issue;
        rd_src_t rd_src;
        logic    wr_en;
        logic    load_work;
        logic    take_pick;
        logic    next_word;
        emit_t   emit;
    } dp_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        cmd_t cmd;
        logic need_zero;
        logic need_over;
        logic mark_ok;
        logic scan_more;
        logic work_free;
        logic got_enough;
        logic last_pick;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/bffa_ifs.sv
// Valid/ready channel interfaces: request, result and register write.
// Depends on bffa_pkg for field widths.
`timescale 1ns / 1ps

interface bffa_req_if import bffa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] block_count;
    logic [MARK_W-1:0]  mark_index;

    modport source (output valid, cmd, block_count, mark_index, input ready);
    modport sink   (input valid, cmd, block_count, mark_index, output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, number, status, last, input ready);
    modport sink   (input valid, number, status, last, output ready);
endinterface

interface bffa_cfg_if import bffa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/bffa_map_ram.sv
// One bitmap store: word memory with a registered read port and a valid
// bit per word so unwritten words read as all free. Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_map_ram import bffa_pkg::*; #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] word_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_vld_reg;
    logic [WORD_W-1:0] rd_word_reg;

    // Track written words; sample the valid bit with the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Word storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= word_mem[rd_addr];
        end
    end

    // Never-written word reads as all free
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

### hw/rtl/bffa_ctrl.sv
// Sequencer for the allocator: decodes a request, steps the word scan,
// the pick loop and the commit writes. Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_ctrl import bffa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t st,
    output dp_ctl_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MARK_WR,
        S_SCAN_RD,
        S_LOAD,
        S_PICK,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_EMIT_FAIL,
        S_EMIT_NONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.cmd)
                    CMD_MARK_INODE, CMD_MARK_DATA:
                    begin
                        if (st.mark_ok)
                        begin
                            ctl.rd_issue = 1'b1;
                            ctl.rd_src   = SRC_MARK;
                            state_next   = S_MARK_WR;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_ALLOC_INODE:
                    begin
                        state_next = S_SCAN_RD;
                    end
                    CMD_ALLOC_DATA:
                    begin
                        priority if (st.need_zero)
                        begin
                            state_next = S_EMIT_NONE;
                        end
                        else if (st.need_over)
                        begin
                            state_next = S_EMIT_FAIL;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_MARK_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.rd_src = SRC_MARK;
                state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                if (st.scan_more)
                begin
                    ctl.rd_issue = 1'b1;
                    ctl.rd_src   = SRC_SCAN;
                    state_next   = S_LOAD;
                end
                else
                begin
                    state_next = S_EMIT_FAIL;
                end
            end
            S_LOAD:
            begin
                ctl.load_work = 1'b1;
                state_next    = S_PICK;
            end
            S_PICK:
            begin
                // Take free bits of this word until enough, else move on
                priority if (st.got_enough)
                begin
                    state_next = S_COMMIT_RD;
                end
                else if (st.work_free)
                begin
                    ctl.take_pick = 1'b1;
                end
                else
                begin
                    ctl.next_word = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_COMMIT_RD:
            begin
                ctl.rd_issue = 1'b1;
                ctl.rd_src   = SRC_PICK;
                state_next   = S_COMMIT_WR;
            end
            S_COMMIT_WR:
            begin
                ctl.rd_src = SRC_PICK;
                if (st.out_free)
                begin
                    ctl.wr_en = 1'b1;
                    ctl.emit  = EMIT_PICK;
                    state_next = st.last_pick ? S_IDLE : S_COMMIT_RD;
                end
            end
            S_EMIT_FAIL:
            begin
                if (st.out_free)
                begin
                    ctl.emit   = EMIT_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_NONE:
            begin
                if (st.out_free)
                begin
                    ctl.emit   = EMIT_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/bffa_datapath.sv
// Allocator datapath: registers, request latch, both bitmap stores, the
// word scan with limit masking, the pick buffer and the result register.
// Depends on bffa_pkg, bffa_ifs and bffa_map_ram.
`timescale 1ns / 1ps
`include "bitmap_first_fit_allocator_assert.svh"

module bffa_datapath import bffa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bffa_req_if.sink   req,
    bffa_rsp_if.source rsp,
    bffa_cfg_if.sink   cfg,
    input  dp_ctl_t    ctl,
    output dp_stat_t   st
);

    logic [INODE_LIM_W-1:0] inode_limit_reg;
    logic [DATA_LIM_W-1:0]  data_limit_reg;
    logic [BASE_W-1:0]      data_base_reg;

    cmd_t                   cmd_reg;
    logic [COUNT_W-1:0]     need_reg;
    logic [MARK_W-1:0]      mark_reg;
    logic [SCAN_W-1:0]      scan_addr_reg;
    logic [WORD_W-1:0]      work_reg;
    logic [MAP_IDX_W-1:0]   picks_reg [MAX_BLOCKS];
    logic [PICK_CNT_W-1:0]  got_reg;
    logic [PICK_CNT_W-1:0]  commit_idx_reg;

    logic                   rsp_valid_reg;
    logic [NUMBER_W-1:0]    number_reg;
    status_t                status_reg;
    logic                   last_reg;

    logic                   sel_data;
    logic [LIM_W-1:0]       map_bits;
    logic [LIM_W-1:0]       lim_raw;
    logic [LIM_W-1:0]       eff_lim;
    logic [SCAN_W-1:0]      full_words;
    logic [SCAN_W-1:0]      word_lim;
    logic [BITPOS_W-1:0]    rem_bits;
    logic [WORD_W-1:0]      tail_mask;
    logic [WORD_W-1:0]      lim_mask;

    logic [MAP_IDX_W-1:0]   pick_cur;
    logic [MAP_IDX_W-1:0]   acc_idx;
    logic [MAP_WADDR_W-1:0] acc_waddr;
    logic [BITPOS_W-1:0]    acc_bit;
    logic [WORD_W-1:0]      inode_rd;
    logic [WORD_W-1:0]      data_rd;
    logic [WORD_W-1:0]      rd_word;
    logic [WORD_W-1:0]      wr_bit;
    logic [WORD_W-1:0]      wr_word;

    logic [WORD_W-1:0]      free_bits;
    logic [WORD_W-1:0]      free_onehot;
    logic [BITPOS_W-1:0]    free_pos;
    logic                   pick_wr;
    logic                   fail_out;

    assign sel_data = (cmd_reg == CMD_ALLOC_DATA) || (cmd_reg == CMD_MARK_DATA);

    // Configuration registers; unknown indexes drop the word
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inode_limit_reg <= INODE_LIMIT_RESET;
            data_limit_reg  <= DATA_LIMIT_RESET;
            data_base_reg   <= DATA_BASE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_INODE_LIMIT: inode_limit_reg <= cfg.data[INODE_LIM_W-1:0];
                CFG_DATA_LIMIT:  data_limit_reg  <= cfg.data[DATA_LIM_W-1:0];
                CFG_DATA_BASE:   data_base_reg   <= cfg.data[BASE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective limit and scan range for the selected bitmap
    assign map_bits   = sel_data ? LIM_W'(DATA_BITS) : LIM_W'(INODE_BITS);
    assign lim_raw    = sel_data ? LIM_W'(data_limit_reg) : LIM_W'(inode_limit_reg);
    assign eff_lim    = (lim_raw > map_bits) ? map_bits : lim_raw;
    assign full_words = SCAN_W'(eff_lim >> BITPOS_W);
    assign rem_bits   = eff_lim[BITPOS_W-1:0];
    assign word_lim   = full_words + SCAN_W'(rem_bits != '0);
    assign tail_mask  = ~((WORD_W'(1) << rem_bits) - WORD_W'(1));

    // Bits at or past the limit look used
    always_comb
    begin
        if (scan_addr_reg < full_words)
        begin
            lim_mask = '0;
        end
        else if (scan_addr_reg == full_words)
        begin
            lim_mask = tail_mask;
        end
        else
        begin
            lim_mask = '1;
        end
    end

    // Word address and bit for reads and writes
    assign pick_cur = picks_reg[commit_idx_reg[PICK_IDX_W-1:0]];

    always_comb
    begin
        unique case (ctl.rd_src)
            SRC_SCAN: acc_idx = {scan_addr_reg[MAP_WADDR_W-1:0], BITPOS_W'(0)};
            SRC_MARK: acc_idx = MAP_IDX_W'(mark_reg);
            SRC_PICK: acc_idx = pick_cur;
            default:  acc_idx = {scan_addr_reg[MAP_WADDR_W-1:0], BITPOS_W'(0)};
        endcase
    end

    assign acc_waddr = acc_idx[MAP_IDX_W-1:BITPOS_W];
    assign acc_bit   = acc_idx[BITPOS_W-1:0];
    assign rd_word   = sel_data ? data_rd : inode_rd;
    assign wr_bit    = WORD_W'(1) << acc_bit;
    assign wr_word   = rd_word | wr_bit;

    bffa_map_ram #(
        .DEPTH (INODE_WORDS)
    ) u_inode_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ctl.rd_issue && !sel_data),
        .rd_addr (acc_waddr[INODE_WADDR_W-1:0]),
        .rd_data (inode_rd),
        .wr_en   (ctl.wr_en && !sel_data),
        .wr_addr (acc_waddr[INODE_WADDR_W-1:0]),
        .wr_data (wr_word)
    );

    bffa_map_ram #(
        .DEPTH (DATA_WORDS)
    ) u_data_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ctl.rd_issue && sel_data),
        .rd_addr (acc_waddr[DATA_WADDR_W-1:0]),
        .rd_data (data_rd),
        .wr_en   (ctl.wr_en && sel_data),
        .wr_addr (acc_waddr[DATA_WADDR_W-1:0]),
        .wr_data (wr_word)
    );

    // Lowest free bit of the working word
    assign free_bits   = ~work_reg;
    assign free_onehot = free_bits & (~free_bits + WORD_W'(1));

    always_comb
    begin
        free_pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (free_onehot[i])
            begin
                free_pos = free_pos | BITPOS_W'(i);
            end
        end
    end

    // Request latch, scan position, pick counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_ALLOC_INODE;
            need_reg       <= '0;
            mark_reg       <= '0;
            scan_addr_reg  <= '0;
            got_reg        <= '0;
            commit_idx_reg <= '0;
        end
        else
        begin
            if (ctl.load_req)
            begin
                cmd_reg        <= cmd_t'(req.cmd);
                need_reg       <= (req.cmd == CMD_ALLOC_INODE) ? COUNT_W'(1)
                                                               : req.block_count;
                mark_reg       <= req.mark_index;
                scan_addr_reg  <= '0;
                got_reg        <= '0;
                commit_idx_reg <= '0;
            end
            if (ctl.next_word)
            begin
                scan_addr_reg <= scan_addr_reg + SCAN_W'(1);
            end
            if (ctl.take_pick)
            begin
                got_reg <= got_reg + PICK_CNT_W'(1);
            end
            if (ctl.emit == EMIT_PICK)
            begin
                commit_idx_reg <= commit_idx_reg + PICK_CNT_W'(1);
            end
        end
    end

    // Working word and pick buffer
    always_ff @(posedge clk)
    begin
        if (ctl.load_work)
        begin
            work_reg <= rd_word | lim_mask;
        end
        else if (ctl.take_pick)
        begin
            work_reg <= work_reg | free_onehot;
        end
        if (ctl.take_pick)
        begin
            picks_reg[got_reg[PICK_IDX_W-1:0]] <=
                {scan_addr_reg[MAP_WADDR_W-1:0], free_pos};
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit != EMIT_IDLE)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.emit)
            EMIT_PICK:
            begin
                number_reg <= sel_data ? data_base_reg + NUMBER_W'(pick_cur)
                                       : NUMBER_W'(pick_cur) + NUMBER_W'(1);
                status_reg <= ST_OK;
                last_reg   <= st.last_pick;
            end
            EMIT_FAIL:
            begin
                number_reg <= '0;
                status_reg <= ST_NO_SPACE;
                last_reg   <= 1'b1;
            end
            EMIT_NONE:
            begin
                number_reg <= '0;
                status_reg <= ST_NONE;
                last_reg   <= 1'b1;
            end
            EMIT_IDLE:
            begin
            end
        endcase
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.number = number_reg;
    assign rsp.status = status_reg;
    assign rsp.last   = last_reg;
    assign req.ready  = ctl.in_ready;

    // Status back to the controller
    assign st.in_valid   = req.valid;
    assign st.cmd        = cmd_reg;
    assign st.need_zero  = (need_reg == '0);
    assign st.need_over  = (int'(need_reg) > MAX_BLOCKS);
    assign st.mark_ok    = (LIM_W'(mark_reg) < map_bits);
    assign st.scan_more  = (scan_addr_reg < word_lim);
    assign st.work_free  = (free_bits != '0);
    assign st.got_enough = (got_reg == PICK_CNT_W'(need_reg));
    assign st.last_pick  = ((commit_idx_reg + PICK_CNT_W'(1)) == got_reg);
    assign st.out_free   = !rsp_valid_reg || rsp.ready;

    assign pick_wr  = ctl.wr_en && (ctl.rd_src == SRC_PICK);
    assign fail_out = rsp_valid_reg && (status_reg != ST_OK);

    // A committed bit must still be free in the map
    `BFFA_ASSERT_IMP(a_pick_was_free, clk, rst_n, pick_wr, (rd_word & wr_bit) == '0, "double pick")
    // Never collect more picks than requested
    `BFFA_ASSERT_IMP(a_pick_bound, clk, rst_n, ctl.take_pick, !st.got_enough, "pick overrun")
    // Failure and empty results end the request and carry no number
    `BFFA_ASSERT_IMP(a_fail_last, clk, rst_n, fail_out, last_reg && number_reg == '0, "bad fail")
    // A new request starts with empty pick counters
    `BFFA_ASSERT_NXT(a_req_clear, clk, rst_n, ctl.load_req, got_reg == '0 && commit_idx_reg == '0, "stale picks")

endmodule

### hw/rtl/bitmap_first_fit_allocator.sv
// Top level of the bitmap first-fit allocator: controller plus datapath.
// Depends on bffa_pkg, bffa_ifs, bffa_ctrl and bffa_datapath.
`timescale 1ns / 1ps

// Usage
//   req : one word per command (cmd, block_count, mark_index); ready is high
//         only while the block is between requests, so one request at a time.
//   rsp : result words (number, status, last); last marks the final word.
//         A mark command gives no result word.
//   cfg : register writes (index 0 inode limit, 1 data limit, 2 data base),
//         always ready; write only while no request is in flight.
// Sequence
//   Mark: decode and read the bitmap word, then write it back with the bit set.
//   Scan: each 32-bit bitmap word examined is read through one read port per
//   bitmap, loaded, and its free bits taken one at a time; then each block
//   committed is a read-modify-write of its bitmap word.
// Reset
//   Both bitmaps read as all free (per-word valid bits clear at once), the
//   limits return to 1024 and 4096 and the base to 0; no clearing pass.
// Stall
//   One output register holds the pending result; while a result is pending and
//   rsp.ready is low the sequencer waits at its next result and takes no new request.
module bitmap_first_fit_allocator import bffa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bffa_req_if.sink   req,
    bffa_rsp_if.source rsp,
    bffa_cfg_if.sink   cfg
);

    dp_ctl_t  ctl;
    dp_stat_t st;

    // Sequencer
    bffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    // Bitmaps, registers and result path
    bffa_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .st    (st)
    );

endmodule
